>>> sv/tbm_pkg.sv
// Shared types and constants for the tilt bubble LED mapper.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package tbm_pkg;

    localparam int LedCount    = 12;
    localparam int LedLast     = LedCount - 1;
    localparam int CordicSteps = 24;
    localparam int VecScale    = 20;
    localparam int VecW        = 39;   // |v| < 2^37 after gain and the diagonal
    localparam int ZW          = 34;   // angle in 2^32 per turn, with headroom
    localparam int SampleW     = 16;
    localparam int ThrW        = 15;
    localparam int SqW         = 31;   // one square of a 16-bit sample
    localparam int RedSqW      = 2 * ThrW;

    localparam logic signed [ZW-1:0] HalfTurn = 34'sh080000000;

    localparam logic [LedCount-1:0] MaskAll  = {LedCount{1'b1}};
    localparam logic [LedCount-1:0] MaskPair = LedCount'(1) | (LedCount'(1) << LedLast);
    localparam logic [LedCount-1:0] MaskLow  = LedCount'(1);
    localparam logic [LedCount-1:0] MaskHigh = LedCount'(1) << LedLast;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] AtanTab [CordicSteps] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680094,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // register index on the configuration port (paddr[2])
    localparam logic RegLevelThr = 1'b0;
    localparam logic RegRedThr   = 1'b1;

    typedef enum logic [1:0] {
        ColGreen  = 2'd0,
        ColOrange = 2'd1,
        ColRed    = 2'd2
    } t_colour;

    // classification that travels alongside the angle pipeline
    typedef struct packed {
        logic                level;
        logic                special;
        logic                zero;
        t_colour             colour;
        logic [LedCount-1:0] spec_mask;
    } t_side;

endpackage

`default_nettype wire

>>> sv/tilt_bubble_led_mapper.sv
// Top level of the tilt bubble LED mapper: configuration registers and the
// front, CORDIC and back pipeline sections. Depends on tbm_pkg and the tbm_* modules.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-----------------------------
//  sample in | start, busy (never high)       | i_x_raw, i_y_raw
//  result    | o_done, one-cycle strobe       | o_led_mask, o_colour
//  config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One item is taken every cycle; each result goes through the 24-stage CORDIC
// plus five stages around it, in the front and back sections.
// Reset is synchronous and active low: it clears the stage valid bits and
// loads the thresholds (level 819, red 8192); the data path holds no state.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
`default_nettype none

module tilt_bubble_led_mapper #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // sample channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [15:0]                i_x_raw,
    input  wire logic signed [15:0]                i_y_raw,
    // result channel
    output logic                                   o_done,
    output logic [11:0]                            o_led_mask,
    output logic [1:0]                             o_colour,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int Latency = tbm_pkg::CordicSteps + 5;

    // configuration registers and the squared red threshold
    logic [tbm_pkg::ThrW-1:0]   r_level_thr, n_level_thr;
    logic [tbm_pkg::ThrW-1:0]   r_red_thr,   n_red_thr;
    logic [tbm_pkg::RedSqW-1:0] r_red_sq;
    logic                       cfg_wr;
    logic                       accept;

    // front -> CORDIC
    logic                            f_vld;
    logic signed [tbm_pkg::VecW-1:0] f_vx, f_vy;
    logic signed [tbm_pkg::ZW-1:0]   f_z;
    tbm_pkg::t_side                  f_side;

    // CORDIC -> back
    logic                            c_vld;
    logic signed [tbm_pkg::ZW-1:0]   c_z;
    tbm_pkg::t_side                  c_side;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    // decode on the word address; the register index is paddr[2]
    always_comb begin
        n_level_thr = r_level_thr;
        n_red_thr   = r_red_thr;
        if (cfg_wr) begin
            case (paddr[2])
                tbm_pkg::RegLevelThr: n_level_thr = pwdata[tbm_pkg::ThrW-1:0];
                tbm_pkg::RegRedThr:   n_red_thr   = pwdata[tbm_pkg::ThrW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tbm_pkg::RegLevelThr: prdata = {{(32-tbm_pkg::ThrW){1'b0}}, r_level_thr};
            tbm_pkg::RegRedThr:   prdata = {{(32-tbm_pkg::ThrW){1'b0}}, r_red_thr};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_thr <= tbm_pkg::ThrW'(819);
            r_red_thr   <= tbm_pkg::ThrW'(8192);
        end else begin
            r_level_thr <= n_level_thr;
            r_red_thr   <= n_red_thr;
        end
    end

    // square the red threshold once, registered; it lags any config write by one register
    always_ff @(posedge i_clk) begin
        r_red_sq <= tbm_pkg::RedSqW'(r_red_thr) * tbm_pkg::RedSqW'(r_red_thr);
    end

    tbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_x_raw     (i_x_raw),
        .i_y_raw     (i_y_raw),
        .i_level_thr (r_level_thr),
        .i_red_sq    (r_red_sq),
        .o_vld       (f_vld),
        .o_vx        (f_vx),
        .o_vy        (f_vy),
        .o_z         (f_z),
        .o_side      (f_side)
    );

    tbm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_vx    (f_vx),
        .i_vy    (f_vy),
        .i_z     (f_z),
        .i_side  (f_side),
        .o_vld   (c_vld),
        .o_z     (c_z),
        .o_side  (c_side)
    );

    tbm_back #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (c_vld),
        .i_z        (c_z),
        .i_side     (c_side),
        .o_done     (o_done),
        .o_led_mask (o_led_mask),
        .o_colour   (o_colour)
    );

    // every accepted item comes out exactly once, a fixed latency later
    a_item_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##Latency o_done)
        else $error("accepted item did not complete on time");

    a_no_invented : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, Latency))
        else $error("result strobe without a matching item");

    // green means level: the whole ring lights
    a_green_ring : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_colour == tbm_pkg::ColGreen) |-> (o_led_mask == tbm_pkg::MaskAll))
        else $error("green result without every LED lit");

    // a tilt lights one LED, or the pair either side of the front gap
    a_tilt_leds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_colour != tbm_pkg::ColGreen)
        |-> ($onehot(o_led_mask) || (o_led_mask == tbm_pkg::MaskPair)))
        else $error("tilt result lights an unexpected LED pattern");

endmodule

`default_nettype wire

>>> sv/tbm_front.sv
// Front end: sample register, level/lean classification, squares, colour
// compare and CORDIC pre-rotation. Depends on tbm_pkg.
`default_nettype none

module tbm_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_accept,
    input  wire logic signed [tbm_pkg::SampleW-1:0]    i_x_raw,
    input  wire logic signed [tbm_pkg::SampleW-1:0]    i_y_raw,
    input  wire logic [tbm_pkg::ThrW-1:0]              i_level_thr,
    input  wire logic [tbm_pkg::RedSqW-1:0]            i_red_sq,
    output logic                                       o_vld,
    output logic signed [tbm_pkg::VecW-1:0]            o_vx,
    output logic signed [tbm_pkg::VecW-1:0]            o_vy,
    output logic signed [tbm_pkg::ZW-1:0]              o_z,
    output tbm_pkg::t_side                             o_side
);

    // stage A: captured sample
    logic                               r_a_vld;
    logic signed [tbm_pkg::SampleW-1:0] r_a_x, r_a_y;

    // stage B: classification, squares, pre-rotated vector
    logic                               r_b_vld;
    logic [tbm_pkg::SqW-1:0]            r_b_x2, r_b_y2;
    logic signed [tbm_pkg::VecW-1:0]    r_b_vx, r_b_vy;
    logic signed [tbm_pkg::ZW-1:0]      r_b_z;
    tbm_pkg::t_side                     r_b_side;

    // stage C: colour settled
    logic                               r_c_vld;
    logic signed [tbm_pkg::VecW-1:0]    r_c_vx, r_c_vy;
    logic signed [tbm_pkg::ZW-1:0]      r_c_z;
    tbm_pkg::t_side                     r_c_side;

    logic signed [tbm_pkg::SampleW:0]   xs, ys;
    logic [tbm_pkg::SampleW:0]          ax, ay, thr;
    logic signed [2*tbm_pkg::SampleW-1:0] xsq, ysq;
    logic signed [tbm_pkg::VecW-1:0]    vx0, vy0;
    logic                               back_lean;
    tbm_pkg::t_side                     n_b_side;
    logic signed [tbm_pkg::VecW-1:0]    n_b_vx, n_b_vy;
    logic signed [tbm_pkg::ZW-1:0]      n_b_z;
    logic [tbm_pkg::SqW:0]              mag_sq;
    tbm_pkg::t_side                     n_c_side;

    always_comb begin
        xs  = {r_a_x[tbm_pkg::SampleW-1], r_a_x};
        ys  = {r_a_y[tbm_pkg::SampleW-1], r_a_y};
        ax  = r_a_x[tbm_pkg::SampleW-1] ? unsigned'(-xs) : unsigned'(xs);
        ay  = r_a_y[tbm_pkg::SampleW-1] ? unsigned'(-ys) : unsigned'(ys);
        thr = {2'b00, i_level_thr};

        xsq = (2*tbm_pkg::SampleW)'(r_a_x) * (2*tbm_pkg::SampleW)'(r_a_x);
        ysq = (2*tbm_pkg::SampleW)'(r_a_y) * (2*tbm_pkg::SampleW)'(r_a_y);

        // y below minus the threshold: backward lean
        back_lean = r_a_y[tbm_pkg::SampleW-1] && (ay > thr);

        n_b_side.level   = (ax < thr) && (ay < thr);
        n_b_side.special = back_lean && (ax != thr);
        n_b_side.zero    = (r_a_x == '0) && (r_a_y == '0);
        n_b_side.colour  = tbm_pkg::ColGreen;
        if (ax < thr) begin
            n_b_side.spec_mask = tbm_pkg::MaskPair;
        end else if (r_a_x[tbm_pkg::SampleW-1]) begin
            n_b_side.spec_mask = tbm_pkg::MaskLow;
        end else begin
            n_b_side.spec_mask = tbm_pkg::MaskHigh;
        end

        // vector (y, x) scaled up; fold the left half plane by a half turn
        vx0 = $signed({{(tbm_pkg::VecW-tbm_pkg::SampleW){r_a_y[tbm_pkg::SampleW-1]}}, r_a_y})
              <<< tbm_pkg::VecScale;
        vy0 = $signed({{(tbm_pkg::VecW-tbm_pkg::SampleW){r_a_x[tbm_pkg::SampleW-1]}}, r_a_x})
              <<< tbm_pkg::VecScale;
        if (r_a_y[tbm_pkg::SampleW-1]) begin
            n_b_vx = -vx0;
            n_b_vy = -vy0;
            n_b_z  = r_a_x[tbm_pkg::SampleW-1] ? -tbm_pkg::HalfTurn : tbm_pkg::HalfTurn;
        end else begin
            n_b_vx = vx0;
            n_b_vy = vy0;
            n_b_z  = '0;
        end
    end

    always_comb begin
        mag_sq   = {1'b0, r_b_x2} + {1'b0, r_b_y2};
        n_c_side = r_b_side;
        if (r_b_side.level) begin
            n_c_side.colour = tbm_pkg::ColGreen;
        end else if (mag_sq >= {{(tbm_pkg::SqW+1-tbm_pkg::RedSqW){1'b0}}, i_red_sq}) begin
            n_c_side.colour = tbm_pkg::ColRed;
        end else begin
            n_c_side.colour = tbm_pkg::ColOrange;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_x <= i_x_raw;
            r_a_y <= i_y_raw;
        end
        r_b_x2   <= xsq[tbm_pkg::SqW-1:0];
        r_b_y2   <= ysq[tbm_pkg::SqW-1:0];
        r_b_vx   <= n_b_vx;
        r_b_vy   <= n_b_vy;
        r_b_z    <= n_b_z;
        r_b_side <= n_b_side;
        r_c_vx   <= r_b_vx;
        r_c_vy   <= r_b_vy;
        r_c_z    <= r_b_z;
        r_c_side <= n_c_side;
    end

    assign o_vld  = r_c_vld;
    assign o_vx   = r_c_vx;
    assign o_vy   = r_c_vy;
    assign o_z    = r_c_z;
    assign o_side = r_c_side;

endmodule

`default_nettype wire

>>> sv/tbm_cordic.sv
// Vectoring CORDIC, one micro-rotation per register stage.
// Depends on tbm_pkg for widths, step count and the arctangent constants.
`default_nettype none

module tbm_cordic (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    input  wire logic signed [tbm_pkg::VecW-1:0]   i_vx,
    input  wire logic signed [tbm_pkg::VecW-1:0]   i_vy,
    input  wire logic signed [tbm_pkg::ZW-1:0]     i_z,
    input  wire tbm_pkg::t_side                    i_side,
    output logic                                   o_vld,
    output logic signed [tbm_pkg::ZW-1:0]          o_z,
    output tbm_pkg::t_side                         o_side
);

    logic                            r_vld  [tbm_pkg::CordicSteps];
    logic signed [tbm_pkg::VecW-1:0] r_vx   [tbm_pkg::CordicSteps];
    logic signed [tbm_pkg::VecW-1:0] r_vy   [tbm_pkg::CordicSteps];
    logic signed [tbm_pkg::ZW-1:0]   r_z    [tbm_pkg::CordicSteps];
    tbm_pkg::t_side                  r_side [tbm_pkg::CordicSteps];

    for (genvar g = 0; g < tbm_pkg::CordicSteps; g++) begin : g_step
        logic                            p_vld;
        logic signed [tbm_pkg::VecW-1:0] p_vx, p_vy;
        logic signed [tbm_pkg::ZW-1:0]   p_z;
        tbm_pkg::t_side                  p_side;
        logic signed [tbm_pkg::ZW-1:0]   ang;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_vx   = i_vx;
            assign p_vy   = i_vy;
            assign p_z    = i_z;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_vx   = r_vx[g-1];
            assign p_vy   = r_vy[g-1];
            assign p_z    = r_z[g-1];
            assign p_side = r_side[g-1];
        end

        assign ang = $signed({{(tbm_pkg::ZW-32){1'b0}}, tbm_pkg::AtanTab[g]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
        end

        // rotate towards the x axis, accumulate the angle turned through
        always_ff @(posedge i_clk) begin
            if (p_vy >= 0) begin
                r_vx[g] <= p_vx + (p_vy >>> g);
                r_vy[g] <= p_vy - (p_vx >>> g);
                r_z[g]  <= p_z + ang;
            end else begin
                r_vx[g] <= p_vx - (p_vy >>> g);
                r_vy[g] <= p_vy + (p_vx >>> g);
                r_z[g]  <= p_z - ang;
            end
            r_side[g] <= p_side;
        end
    end

    assign o_vld  = r_vld[tbm_pkg::CordicSteps-1];
    assign o_z    = r_z[tbm_pkg::CordicSteps-1];
    assign o_side = r_side[tbm_pkg::CordicSteps-1];

endmodule

`default_nettype wire

>>> sv/tbm_back.sv
// Back end: angle quantisation, LED index rounding and clamp, result register.
// Depends on tbm_pkg.
`default_nettype none

module tbm_back #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    input  wire logic signed [tbm_pkg::ZW-1:0]     i_z,
    input  wire tbm_pkg::t_side                    i_side,
    output logic                                   o_done,
    output logic [tbm_pkg::LedCount-1:0]           o_led_mask,
    output logic [1:0]                             o_colour
);

    localparam int AW   = ANGLE_BITS + 2;   // quantised angle
    localparam int VW   = ANGLE_BITS + 3;   // angle plus index offset
    localparam int IdxW = 5;

    localparam logic signed [tbm_pkg::ZW-1:0] ZRound = tbm_pkg::ZW'(1) <<< (31 - ANGLE_BITS);
    localparam logic signed [VW-1:0] Offset = VW'(tbm_pkg::LedLast) <<< (ANGLE_BITS - 5);
    localparam logic signed [VW-1:0] IRound = VW'(1) <<< (ANGLE_BITS - 5);

    logic                   r_d_vld;
    logic signed [AW-1:0]   r_d_ang;
    tbm_pkg::t_side         r_d_side;

    logic                   r_done;
    logic [tbm_pkg::LedCount-1:0] r_led_mask;
    tbm_pkg::t_colour       r_colour;

    logic signed [tbm_pkg::ZW-1:0] z_q;
    logic signed [AW-1:0]   n_d_ang;
    logic signed [VW-1:0]   v, v_rnd;
    logic [IdxW-1:0]        idx_raw;
    logic [3:0]             idx;
    logic [tbm_pkg::LedCount-1:0] n_led_mask;

    always_comb begin
        z_q     = (i_z + ZRound) >>> (32 - ANGLE_BITS);
        n_d_ang = i_side.zero ? '0 : z_q[AW-1:0];
    end

    always_comb begin
        v       = Offset + {{(VW-AW){r_d_ang[AW-1]}}, r_d_ang};
        v_rnd   = v + IRound;
        idx_raw = v_rnd[ANGLE_BITS:ANGLE_BITS-4];
        if (v < 0) begin
            idx = '0;
        end else if (idx_raw > IdxW'(tbm_pkg::LedLast)) begin
            idx = 4'(tbm_pkg::LedLast);
        end else begin
            idx = idx_raw[3:0];
        end

        if (r_d_side.level) begin
            n_led_mask = tbm_pkg::MaskAll;
        end else if (r_d_side.special) begin
            n_led_mask = r_d_side.spec_mask;
        end else begin
            n_led_mask = tbm_pkg::LedCount'(1) << idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_d_vld <= i_vld;
            r_done  <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_ang    <= n_d_ang;
        r_d_side   <= i_side;
        r_led_mask <= n_led_mask;
        r_colour   <= r_d_side.colour;
    end

    assign o_done     = r_done;
    assign o_led_mask = r_led_mask;
    assign o_colour   = r_colour;

endmodule

`default_nettype wire
